// ----- hdl/ptts_pkg.sv -----
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and codes shared by the periodic task tick scheduler modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int unsigned IvBits = 18;

  typedef enum logic [2:0] {
    K_TICK    = 3'd0,
    K_ADD     = 3'd1,
    K_PAUSE   = 3'd2,
    K_RESTART = 3'd3,
    K_MODIFY  = 3'd4,
    K_REMOVE  = 3'd5,
    K_QUERY   = 3'd6,
    K_BAD     = 3'd7
  } kind_e;

  localparam logic [1:0] MODE_PAUSED   = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ONESHOT  = 2'd2;
  localparam logic [2:0] ADD_MODE_MAX  = 3'd5;

  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_MAX_IV  = 1'b1;

  localparam logic [IvBits-1:0] MAX_IV_RESET = 18'd225000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id;
    logic [23:0] interval;
    logic [2:0]  mode;
  } in_t;

  typedef struct packed {
    logic       reply_kind;
    logic [7:0] task_id_res;
    logic       error;
    logic       found;
    logic [1:0] task_mode;
    logic       last;
  } out_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         task_id;
    logic [IvBits-1:0]  iv;
    logic [1:0]         mode;
    logic               imm;
    logic               set_mode;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PUSH = 4'b0100,
    S_TICK = 4'b1000
  } state_e;

endpackage

// ----- hdl/ptts_front.sv -----
// ----------------------------------------------------------------------------
// ptts_front
// Accepts input beats, decodes them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ptts_front import ptts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_i,
  input  logic [IvBits-1:0] max_iv_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       dec;
  cmd_t       q_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  always_comb begin
    dec.kind     = kind_e'(in_i.kind);
    dec.task_id  = in_i.task_id;
    if (in_i.interval == 24'd0 || in_i.interval > {6'd0, max_iv_i}) begin
      dec.iv = IvBits'(1);
    end else begin
      dec.iv = in_i.interval[IvBits-1:0];
    end
    dec.set_mode = (in_i.mode[1:0] == MODE_PERIODIC || in_i.mode[1:0] == MODE_ONESHOT)
                   && !in_i.mode[2];
    if (in_i.mode > ADD_MODE_MAX) begin
      dec.mode = MODE_PERIODIC;
      dec.imm  = 1'b0;
    end else begin
      dec.mode = in_i.mode[1:0];
      dec.imm  = in_i.mode[2];
    end
  end

  assign in_stall_o  = cnt_q[1];
  assign push        = in_valid_i && !cnt_q[1];
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= dec;
    end
  end

endmodule

// ----- hdl/ptts_back.sv -----
// ----------------------------------------------------------------------------
// ptts_back
// Executes commands and ticks against the task slot table, walking one slot
// per cycle while the result port is not stalled, and drives the registered result port.
// ----------------------------------------------------------------------------
module ptts_back import ptts_pkg::*; #(
  parameter int unsigned TASK_SLOTS   = 8,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [IvBits-1:0] cfg_data_i,
  output logic [IvBits-1:0] max_iv_o,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_o,
  output logic [$clog2(TASK_SLOTS+1)-1:0] count_o
);

  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned SW = COUNTER_BITS + IvBits;

  logic [7:0]        id_q  [TASK_SLOTS];
  logic [1:0]        md_q  [TASK_SLOTS];
  logic [IvBits-1:0] iv_q  [TASK_SLOTS];
  logic [CB-1:0]     due_q [TASK_SLOTS];

  state_e            state_q, state_d;
  logic              en_q;
  logic [IvBits-1:0] max_iv_q;
  logic [CB-1:0]     tick_q, tick_d;
  logic [CW-1:0]     cnt_q, cnt_d, i_q, i_d;
  cmd_t              cmd_q;
  out_t              rep_q, rep_d;
  logic              pend_v_q, pend_v_d;
  logic [7:0]        pend_id_q, pend_id_d;
  logic              out_valid_q;
  out_t              out_q, push_data;
  logic              push, can_push, in_range, fire;

  logic [IW-1:0]     ix, cx;
  logic [7:0]        cid;
  logic [1:0]        cmode;
  logic [IvBits-1:0] civ;
  logic [CB-1:0]     cdue, diff, due_cur, due_cmd, due_add;
  logic [SW-1:0]     sum_cur, sum_cmd, sum_add;

  logic              w_add, w_mode, w_iv, w_due, w_shift;
  logic [1:0]        w_mode_val;
  logic [CB-1:0]     w_due_val;

  assign ix       = i_q[IW-1:0];
  assign cx       = cnt_q[IW-1:0];
  assign cid      = id_q[ix];
  assign cmode    = md_q[ix];
  assign civ      = iv_q[ix];
  assign cdue     = due_q[ix];
  assign in_range = i_q < cnt_q;
  assign diff     = tick_q - cdue;
  assign fire     = in_range && cmode != MODE_PAUSED && !diff[CB-1];
  assign sum_cur  = SW'(tick_q) + SW'(civ);
  assign sum_cmd  = SW'(tick_q) + SW'(cmd_q.iv);
  assign sum_add  = SW'(tick_q) + (cmd_i.imm ? SW'(0) : SW'(cmd_i.iv));
  assign due_cur  = sum_cur[CB-1:0];
  assign due_cmd  = sum_cmd[CB-1:0];
  assign due_add  = sum_add[CB-1:0];
  assign can_push = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    rep_d      = rep_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    push       = 1'b0;
    push_data  = '0;
    cmd_pop_o  = 1'b0;
    w_add      = 1'b0;
    w_mode     = 1'b0;
    w_iv       = 1'b0;
    w_due      = 1'b0;
    w_shift    = 1'b0;
    w_mode_val = MODE_PAUSED;
    w_due_val  = due_cur;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o         = 1'b1;
          rep_d             = '0;
          rep_d.task_id_res = cmd_i.task_id;
          rep_d.last        = 1'b1;
          i_d               = '0;
          if (cmd_i.kind == K_TICK) begin
            if (en_q) begin
              tick_d   = tick_q + CB'(1);
              pend_v_d = 1'b0;
              state_d  = S_TICK;
            end
          end else if (!en_q || cmd_i.kind == K_BAD) begin
            rep_d.error = 1'b1;
            state_d     = S_PUSH;
          end else if (cmd_i.kind == K_ADD) begin
            if (cnt_q == CW'(TASK_SLOTS)) begin
              rep_d.error = 1'b1;
            end else begin
              w_add = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end
            state_d = S_PUSH;
          end else if (cnt_q == '0) begin
            rep_d.error = 1'b1;
            state_d     = S_PUSH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!in_range) begin
          rep_d.error = cmd_q.kind == K_MODIFY;
          state_d     = S_PUSH;
        end else if (cid == cmd_q.task_id) begin
          state_d = S_PUSH;
          unique case (cmd_q.kind)
            K_PAUSE: begin
              w_mode = 1'b1;
            end
            K_RESTART: begin
              w_mode     = 1'b1;
              w_mode_val = MODE_PERIODIC;
              w_due      = 1'b1;
            end
            K_MODIFY: begin
              w_mode     = cmd_q.set_mode;
              w_mode_val = cmd_q.mode;
              w_iv       = 1'b1;
              w_due      = 1'b1;
              w_due_val  = due_cmd;
            end
            K_REMOVE: begin
              w_shift = 1'b1;
              cnt_d   = cnt_q - CW'(1);
            end
            K_QUERY: begin
              rep_d.found     = 1'b1;
              rep_d.task_mode = cmode;
            end
            default: begin
            end
          endcase
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_PUSH: begin
        if (can_push) begin
          push      = 1'b1;
          push_data = rep_q;
          state_d   = S_IDLE;
        end
      end
      S_TICK: begin
        push_data.reply_kind  = 1'b1;
        push_data.task_id_res = pend_id_q;
        if (!in_range) begin
          if (!pend_v_q) begin
            state_d = S_IDLE;
          end else if (can_push) begin
            push           = 1'b1;
            push_data.last = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (fire) begin
          if (!pend_v_q || can_push) begin
            push      = pend_v_q;
            pend_v_d  = 1'b1;
            pend_id_d = cid;
            if (cmode == MODE_ONESHOT) begin
              w_shift = 1'b1;
              cnt_d   = cnt_q - CW'(1);
            end else begin
              w_due = 1'b1;
              i_d   = i_q + CW'(1);
            end
          end
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i && cfg_idx_i == CFG_ENABLE && cfg_data_i[0] && !en_q) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      en_q        <= 1'b0;
      max_iv_q    <= MAX_IV_RESET;
      tick_q      <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      i_q      <= i_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i && cfg_idx_i == CFG_ENABLE) begin
        en_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_MAX_IV) begin
        max_iv_q <= cfg_data_i;
      end
      out_valid_q <= push || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q     <= rep_d;
    pend_id_q <= pend_id_d;
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (push) begin
      out_q <= push_data;
    end
    if (w_add) begin
      id_q[cx]  <= cmd_i.task_id;
      md_q[cx]  <= cmd_i.mode;
      iv_q[cx]  <= cmd_i.iv;
      due_q[cx] <= due_add;
    end
    if (w_mode) begin
      md_q[ix] <= w_mode_val;
    end
    if (w_iv) begin
      iv_q[ix] <= cmd_q.iv;
    end
    if (w_due) begin
      due_q[ix] <= w_due_val;
    end
    if (w_shift) begin
      for (int j = 0; j < TASK_SLOTS - 1; j++) begin
        if (CW'(j) >= i_q) begin
          id_q[j]  <= id_q[j+1];
          md_q[j]  <= md_q[j+1];
          iv_q[j]  <= iv_q[j+1];
          due_q[j] <= due_q[j+1];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign max_iv_o    = max_iv_q;
  assign count_o     = cnt_q;

endmodule

// ----- hdl/periodic_task_tick_scheduler.sv -----
// A command beat waits in the front end queue until the back end is idle, is
// searched slot by slot where needed, and has its reply registered onto the result
// port. A tick walks every occupied slot when enabled, one slot per cycle while the
// result port is not stalled. The single slot walker takes no new beat until it is
// done with the last one. Reset clears the tick counter, task count and handshake
// state; slot contents are left as they are and are only read once written.
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Top level: decoding front end with queue, slot table back end.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler import ptts_pkg::*; #(
  parameter int unsigned TASK_SLOTS   = 8,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [IvBits-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_o
);

  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;
  logic [IvBits-1:0] max_iv;
  logic [$clog2(TASK_SLOTS+1)-1:0] count;

  ptts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .max_iv_i    (max_iv),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ptts_back #(
    .TASK_SLOTS   (TASK_SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .max_iv_o    (max_iv),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .count_o     (count)
  );

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= ($clog2(TASK_SLOTS+1))'(TASK_SLOTS))
    else $error("task count exceeds slot table");

  a_reply_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.reply_kind |-> out_o.last)
    else $error("command reply not marked last");

  a_fire_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.reply_kind |-> !out_o.error && !out_o.found)
    else $error("fired beat carries reply fields");

  a_pop_only_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");
`endif

endmodule
